@@ rtl/pvc_pkg.sv @@
package pvc_pkg;

  localparam int CharW         = 8;
  localparam int OffW          = 7;
  localparam int LenW          = 5;
  localparam int KeyIdxW       = 4;
  localparam int KeyChars      = 16;
  localparam int KeyMaxDefault = 16;
  localparam int CfgIdxW       = 8;
  localparam int CfgDataW      = 64;
  localparam int QueueDepth    = 2;

  localparam logic [CharW-1:0] AlphaSize  = 8'd95;
  localparam logic [CharW-1:0] FirstPrint = 8'd32;
  localparam logic [CharW-1:0] LastPrint  = 8'd126;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgDecodeMode = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyLength  = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyLow     = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh    = 8'd3;

  typedef logic [CharW-1:0] char_t;

  // one classified byte between front and back
  typedef struct packed {
    char_t             data;    // offset from 32 when printable, raw byte otherwise
    logic              passed;
    logic [OffW-1:0]   koff;    // key offset, 0 to 94
  } pvc_entry_t;

endpackage

@@ rtl/pvc_front.sv @@
module pvc_front #(
  parameter int KEY_MAX = pvc_pkg::KeyMaxDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  pvc_pkg::char_t                        in_byte_i,
  input  logic                                  start_of_message_i,
  input  logic [pvc_pkg::LenW-1:0]              key_length_i,
  input  logic [pvc_pkg::KeyChars*pvc_pkg::CharW-1:0] key_chars_i,
  input  logic                                  q_full_i,
  output logic                                  q_push_o,
  output pvc_pkg::pvc_entry_t                   q_entry_o
);
  import pvc_pkg::*;

  localparam int PosW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam logic [LenW-1:0] LenMax = LenW'(KEY_MAX);

  logic [PosW-1:0]    pos_q, pos_d;
  logic [LenW-1:0]    len_eff;
  logic [LenW-1:0]    pos_cur, pos_use, pos_inc;
  logic [KeyIdxW-1:0] key_idx;
  char_t              key_ch;
  logic               printable;
  logic               accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    len_eff = key_length_i;
    if (len_eff == '0) len_eff = LenW'(1);
    if (len_eff > LenMax) len_eff = LenMax;
  end

  assign printable = (in_byte_i >= FirstPrint) && (in_byte_i <= LastPrint);

  always_comb begin
    pos_cur = start_of_message_i ? '0 : LenW'(pos_q);
    // position left over from a longer key falls back to the first character
    pos_use = (pos_cur >= len_eff) ? '0 : pos_cur;
    pos_inc = pos_use + LenW'(1);
    if (pos_inc >= len_eff) pos_inc = '0;
    key_idx = KeyIdxW'(pos_use);
    key_ch  = key_chars_i[key_idx*CharW +: CharW];
  end

  always_comb begin
    q_entry_o.passed = ~printable;
    q_entry_o.data   = printable ? (in_byte_i - FirstPrint) : in_byte_i;
    if ((key_ch >= FirstPrint) && (key_ch <= LastPrint)) begin
      q_entry_o.koff = OffW'(key_ch - FirstPrint);
    end else begin
      q_entry_o.koff = '0;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (printable) begin
        pos_d = PosW'(pos_inc);
      end else if (start_of_message_i) begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ rtl/pvc_queue.sv @@
module pvc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pvc_pkg::pvc_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output pvc_pkg::pvc_entry_t entry_o,
  output logic                empty_o
);
  import pvc_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  pvc_entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

@@ rtl/pvc_back.sv @@
module pvc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                decode_mode_i,
  input  logic                q_empty_i,
  input  pvc_pkg::pvc_entry_t q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pvc_pkg::char_t      out_byte_o,
  output logic                passed_through_o
);
  import pvc_pkg::*;

  logic  valid_q, valid_d;
  char_t byte_q, byte_d;
  logic  passed_q, passed_d;
  char_t addend, sum;
  logic  load;

  // output register frees up when empty or when its transfer completes
  assign load    = ~q_empty_i & (~valid_q | ~out_stall_i);
  assign q_pop_o = load;

  always_comb begin
    // decoding adds the complement so both directions share one reduction
    addend = decode_mode_i ? (AlphaSize - CharW'(q_entry_i.koff)) : CharW'(q_entry_i.koff);
    sum    = q_entry_i.data + addend;
    if (sum >= AlphaSize) sum = sum - AlphaSize;
  end

  always_comb begin
    valid_d  = valid_q;
    byte_d   = byte_q;
    passed_d = passed_q;
    if (load) begin
      valid_d  = 1'b1;
      passed_d = q_entry_i.passed;
      byte_d   = q_entry_i.passed ? q_entry_i.data : (sum + FirstPrint);
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    passed_q <= passed_d;
  end

  assign out_valid_o      = valid_q;
  assign out_byte_o       = byte_q;
  assign passed_through_o = passed_q;

endmodule

@@ rtl/printable_vigenere_cipher.sv @@
// The front writes the queue when an input byte transfers; the back then loads the
// output register from the queue once that register is empty or not stalled.
// Throughput: 1 byte per cycle while the output is not stalled; the key position
// register in the front feeds back on itself with no further register in the loop.
// Reset: async active low; key position 0, encode mode, key length 1, key zero,
// queue and output register empty.
module printable_vigenere_cipher #(
  parameter int KEY_MAX = pvc_pkg::KeyMaxDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pvc_pkg::char_t                in_byte_i,
  input  logic                          start_of_message_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pvc_pkg::char_t                out_byte_o,
  output logic                          passed_through_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pvc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pvc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pvc_pkg::*;

  logic                decode_mode_q;
  logic [LenW-1:0]     key_length_q;
  logic [CfgDataW-1:0] key_low_q, key_high_q;
  logic                q_full, q_empty, q_push, q_pop;
  pvc_entry_t          q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_mode_q <= 1'b0;
      key_length_q  <= LenW'(1);
      key_low_q     <= '0;
      key_high_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDecodeMode: decode_mode_q <= cfg_data_i[0];
        CfgKeyLength:  key_length_q  <= cfg_data_i[LenW-1:0];
        CfgKeyLow:     key_low_q     <= cfg_data_i;
        CfgKeyHigh:    key_high_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pvc_front #(
    .KEY_MAX(KEY_MAX)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_byte_i          (in_byte_i),
    .start_of_message_i (start_of_message_i),
    .key_length_i       (key_length_q),
    .key_chars_i        ({key_high_q, key_low_q}),
    .q_full_i           (q_full),
    .q_push_o           (q_push),
    .q_entry_o          (q_in)
  );

  pvc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .empty_o (q_empty)
  );

  pvc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .decode_mode_i    (decode_mode_q),
    .q_empty_i        (q_empty),
    .q_entry_i        (q_out),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .passed_through_o (passed_through_o)
  );

endmodule

@@ tb/printable_vigenere_cipher_tb.sv @@
module printable_vigenere_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pvc_pkg::*;

  localparam int KeyMax      = 16;
  localparam int ResetCycles = 10;
  localparam int SettleTail  = 6;
  localparam int CycleLimit  = 100000;
  localparam int PrintCap    = 100;
  localparam int Phases      = 12;
  localparam int PhaseBytes  = 46;

  localparam logic [CfgIdxW-1:0] CfgUnused = CfgKeyHigh + 1'b1;

  typedef struct packed {
    char_t data;
    logic  passed;
  } cipher_out_t;

  class cipher_scoreboard;
    logic                decode;
    logic [LenW-1:0]     key_len;
    logic [63:0]         key_lo;
    logic [63:0]         key_hi;
    logic [KeyIdxW-1:0]  key_pos;
    cipher_out_t         expected_bytes[$];
    int                  mismatches;

    function new();
      decode     = 1'b0;
      key_len    = LenW'(1);
      key_lo     = '0;
      key_hi     = '0;
      key_pos    = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgDecodeMode: decode  = data[0];
        CfgKeyLength:  key_len = data[LenW-1:0];
        CfgKeyLow:     key_lo  = data;
        CfgKeyHigh:    key_hi  = data;
        default: ;
      endcase
    endfunction

    // predicts the cipher output of one accepted input byte
    function void note_byte(char_t b, logic som);
      int unsigned span, p, k, v;
      logic [63:0] word;
      char_t       kc;
      cipher_out_t r;
      if (som) key_pos = '0;
      if (b < FirstPrint || b > LastPrint) begin
        r.data   = b;
        r.passed = 1'b1;
      end else begin
        span = (key_len == 0) ? 1 : ((key_len > KeyMax) ? KeyMax : key_len);
        p = key_pos;
        if (p >= span) p = 0;
        word = (p < 8) ? key_lo : key_hi;
        kc = word[(p % 8) * 8 +: 8];
        k = (kc < FirstPrint || kc > LastPrint) ? 0 : kc - FirstPrint;
        v = b - FirstPrint;
        v = decode ? (v + AlphaSize - k) % AlphaSize : (v + k) % AlphaSize;
        p = p + 1;
        if (p >= span) p = 0;
        key_pos  = KeyIdxW'(p);
        r.data   = char_t'(v + FirstPrint);
        r.passed = 1'b0;
      end
      expected_bytes.push_back(r);
    endfunction

    task report(string msg);
      if (mismatches < PrintCap) $display("MISMATCH %s", msg);
      mismatches++;
    endtask

    task check_byte(char_t b, logic pt);
      cipher_out_t e;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected output byte %02h passed_through %b", b, pt));
        return;
      end
      e = expected_bytes.pop_front();
      if (b !== e.data || pt !== e.passed)
        report($sformatf("out_byte %02h passed_through %b, expected %02h %b",
                         b, pt, e.data, e.passed));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  char_t               in_byte_i;
  logic                start_of_message_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  char_t               out_byte_o;
  logic                passed_through_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cipher_scoreboard sb = new;
  bit               no_idle = 1'b0;
  int unsigned      cycles = 0;

  printable_vigenere_cipher #(
    .KEY_MAX(KeyMax)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_byte_i          (in_byte_i),
    .start_of_message_i (start_of_message_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_byte_o         (out_byte_o),
    .passed_through_o   (passed_through_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_byte(out_byte_o, passed_through_o);
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < 21);
  end

  task automatic send_byte(input char_t b, input logic som);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_byte_i          <= b;
    start_of_message_i <= som;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b, som);
  endtask

  // stop feeding and wait for every predicted byte plus pipeline slack
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleTail) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic write_setting(input logic mode, input logic [LenW-1:0] len,
                               input logic [63:0] lo, input logic [63:0] hi);
    cfg_write(CfgDecodeMode, CfgDataW'(mode));
    cfg_write(CfgKeyLength, CfgDataW'(len));
    cfg_write(CfgKeyLow, lo);
    cfg_write(CfgKeyHigh, hi);
    // stray index, must be ignored
    if ($urandom_range(0, 3) == 0)
      cfg_write(CfgIdxW'($urandom_range(CfgUnused, 255)), {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_key();
    logic [63:0] w;
    for (int i = 0; i < 8; i++)
      w[i * 8 +: 8] = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(32, 126))
                                                   : 8'($urandom_range(0, 255));
    return w;
  endfunction

  initial begin
    int          sent, msg_len;
    bit          framed;
    logic [LenW-1:0] len;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    in_byte_i          = '0;
    start_of_message_i = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = '0;
    cfg_data_i         = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: key length 1, key char 0 is non-printable so offset 0
    send_byte(8'h00, 1'b1);
    send_byte(8'd31, 1'b0);
    send_byte(8'd32, 1'b0);
    send_byte(8'd126, 1'b0);
    send_byte(8'd127, 1'b0);
    send_byte(8'hFF, 1'b0);
    settle();

    // max offsets, non-printable key chars mixed into the upper half
    write_setting(1'b0, LenW'(16), 64'h7E7E_7E7E_7E7E_7E7E, 64'h7E20_FF1F_7F00_207E);
    send_byte(8'd126, 1'b1);
    send_byte(8'd32, 1'b0);
    send_byte(8'd126, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'd80, 1'b0);
    send_byte(8'd126, 1'b0);
    send_byte(8'd32, 1'b0);
    send_byte(8'd65, 1'b0);
    send_byte(8'd90, 1'b0);
    send_byte(8'd100, 1'b0);
    settle();

    // key position now past the shortened length: falls back to char 0
    cfg_write(CfgKeyLength, CfgDataW'(3));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    send_byte(8'd120, 1'b0);
    // start flag on a non-printable byte still rewinds the key
    send_byte(8'h0D, 1'b1);
    send_byte(8'd50, 1'b0);
    settle();

    // zero length acts as one
    write_setting(1'b1, LenW'(0), 64'h7E7E_7E7E_7E7E_7E7E, 64'h0);
    send_byte(8'd32, 1'b1);
    send_byte(8'd126, 1'b0);
    settle();

    // length above the maximum saturates
    write_setting(1'b1, LenW'(31), 64'hFFFF_FFFF_FFFF_FFFF, 64'h7E7E_7E7E_7E7E_7E7E);
    send_byte(8'd40, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'd33, 1'b0);
    settle();

    for (int ph = 0; ph < Phases; ph++) begin
      no_idle = (ph == 5 || ph == 6);
      case (ph)
        0: write_setting(1'b0, LenW'(16), 64'h7E7E_7E7E_7E7E_7E7E, 64'h7E7E_7E7E_7E7E_7E7E);
        1: write_setting(1'b1, LenW'(16), 64'h7E7E_7E7E_7E7E_7E7E, 64'h7E7E_7E7E_7E7E_7E7E);
        2: write_setting(1'b0, LenW'(1), 64'h2020_2020_2020_2020, 64'hFFFF_FFFF_FFFF_FFFF);
        default: begin
          len = ($urandom_range(0, 99) < 15) ? LenW'($urandom_range(0, 31))
                                             : LenW'($urandom_range(1, 16));
          write_setting(1'($urandom_range(0, 1)), len, rand_key(), rand_key());
        end
      endcase
      sent = 0;
      while (sent < PhaseBytes) begin
        msg_len = $urandom_range(1, 40);
        if (msg_len > PhaseBytes - sent) msg_len = PhaseBytes - sent;
        framed  = ($urandom_range(0, 9) != 0);
        for (int j = 0; j < msg_len; j++) begin
          send_byte(($urandom_range(0, 99) < 85) ? char_t'($urandom_range(32, 126))
                                                 : char_t'($urandom_range(0, 255)),
                    (j == 0) ? framed : ($urandom_range(0, 99) < 2));
          sent++;
        end
      end
      settle();
    end
    no_idle = 1'b0;

    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
